// ===== sv/ssk_pkg.sv =====
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared constants, codes and controller/datapath types of the sorted
// string key table.
// ----------------------------------------------------------------------------
`default_nettype none

package ssk_pkg;

    localparam int ENTRIES     = 128;
    localparam int TITLE_CHARS = 64;
    localparam int CODE_CHARS  = 32;
    localparam int MAX_CHARS   = (TITLE_CHARS > CODE_CHARS) ? TITLE_CHARS : CODE_CHARS;

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int POS_W  = $clog2(MAX_CHARS + 1);
    localparam int J_W    = $clog2(MAX_CHARS);
    localparam int TB_W   = $clog2(TITLE_CHARS);
    localparam int CB_W   = $clog2(CODE_CHARS);
    localparam int TLEN_W = $clog2(TITLE_CHARS + 1);
    localparam int CLEN_W = $clog2(CODE_CHARS + 1);
    localparam int TA_W   = $clog2(ENTRIES * TITLE_CHARS);
    localparam int CA_W   = $clog2(ENTRIES * CODE_CHARS);

    localparam int OPC_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int QTY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 7;
    localparam int SUM_W    = 23;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    localparam logic [OPC_W-1:0] OPC_INSERT     = 3'd0;
    localparam logic [OPC_W-1:0] OPC_FIND_TITLE = 3'd1;
    localparam logic [OPC_W-1:0] OPC_SET_QTY    = 3'd2;
    localparam logic [OPC_W-1:0] OPC_DELETE     = 3'd3;
    localparam logic [OPC_W-1:0] OPC_FIND_CODE  = 3'd4;
    localparam logic [OPC_W-1:0] OPC_TOTAL      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        REL_LT,
        REL_EQ,
        REL_GT
    } rel_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_ACCEPT,
        OP_SRCH,
        OP_CISSUE,
        OP_CEVAL,
        OP_CSORD,
        OP_QRD,
        OP_QUSE,
        OP_DRD,
        OP_DWR,
        OP_DFIN,
        OP_IFREE,
        OP_CPRD,
        OP_CPWR,
        OP_IQW,
        OP_ISRD,
        OP_ISWR,
        OP_IFIN,
        OP_TORD,
        OP_TQRD,
        OP_TADD,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        logic   s_ready;
        dp_op_t op;
    } ssk_cmd_t;

    typedef struct packed {
        logic             init_last;
        logic             beat_last;
        logic [OPC_W-1:0] beat_opc;
        logic [OPC_W-1:0] opc;
        logic             full;
        logic             srch_more;
        logic             cmp_done;
        rel_t             cmp_rel;
        logic             k_more;
        logic             d_more;
        logic             sh_more;
        logic             copy_last;
        logic             out_free;
    } ssk_stat_t;

endpackage

`default_nettype wire

// ===== sv/ssk_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssk_ctrl
// Sequencer of the table: steps search, compare, copy, shift and sum
// phases and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssk_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ssk_pkg::ssk_stat_t stat,
    output ssk_pkg::ssk_cmd_t      cmd
);

    typedef enum logic [21:0] {
        S_INIT   = 22'h000001,
        S_IDLE   = 22'h000002,
        S_SRCH   = 22'h000004,
        S_CISSUE = 22'h000008,
        S_CEVAL  = 22'h000010,
        S_CSORD  = 22'h000020,
        S_QRD    = 22'h000040,
        S_QUSE   = 22'h000080,
        S_DRD    = 22'h000100,
        S_DWR    = 22'h000200,
        S_DFIN   = 22'h000400,
        S_IFREE  = 22'h000800,
        S_CPRD   = 22'h001000,
        S_CPWR   = 22'h002000,
        S_IQW    = 22'h004000,
        S_ISRD   = 22'h008000,
        S_ISWR   = 22'h010000,
        S_IFIN   = 22'h020000,
        S_TORD   = 22'h040000,
        S_TQRD   = 22'h080000,
        S_TADD   = 22'h100000,
        S_DONE   = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd.s_ready = 1'b0;
        cmd.op      = ssk_pkg::OP_NONE;
        case (state_reg)
            S_INIT: begin
                cmd.op = ssk_pkg::OP_INIT;
                if (stat.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.s_ready = 1'b1;
                cmd.op      = ssk_pkg::OP_ACCEPT;
                if (stat.beat_last) begin
                    case (stat.beat_opc)
                        ssk_pkg::OPC_INSERT: begin
                            state_next = stat.full ? S_DONE : S_SRCH;
                        end
                        ssk_pkg::OPC_FIND_TITLE,
                        ssk_pkg::OPC_SET_QTY,
                        ssk_pkg::OPC_DELETE:  state_next = S_SRCH;
                        ssk_pkg::OPC_FIND_CODE: state_next = S_CSORD;
                        ssk_pkg::OPC_TOTAL:     state_next = S_TORD;
                        default:                state_next = S_IDLE;
                    endcase
                end
            end
            S_SRCH: begin
                cmd.op = ssk_pkg::OP_SRCH;
                if (stat.srch_more) begin
                    state_next = S_CISSUE;
                end else if (stat.opc == ssk_pkg::OPC_INSERT) begin
                    state_next = S_IFREE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_CISSUE: begin
                cmd.op     = ssk_pkg::OP_CISSUE;
                state_next = S_CEVAL;
            end
            S_CEVAL: begin
                cmd.op = ssk_pkg::OP_CEVAL;
                if (!stat.cmp_done) begin
                    state_next = S_CISSUE;
                end else if (stat.opc == ssk_pkg::OPC_FIND_CODE) begin
                    state_next = (stat.cmp_rel == ssk_pkg::REL_EQ) ? S_QRD : S_CSORD;
                end else if (stat.opc == ssk_pkg::OPC_INSERT) begin
                    state_next = S_SRCH;
                end else begin
                    state_next = (stat.cmp_rel == ssk_pkg::REL_EQ) ? S_QRD : S_SRCH;
                end
            end
            S_CSORD: begin
                cmd.op     = ssk_pkg::OP_CSORD;
                state_next = stat.k_more ? S_CISSUE : S_DONE;
            end
            S_QRD: begin
                cmd.op     = ssk_pkg::OP_QRD;
                state_next = S_QUSE;
            end
            S_QUSE: begin
                cmd.op     = ssk_pkg::OP_QUSE;
                state_next = (stat.opc == ssk_pkg::OPC_DELETE) ? S_DRD : S_DONE;
            end
            S_DRD: begin
                cmd.op     = ssk_pkg::OP_DRD;
                state_next = stat.d_more ? S_DWR : S_DFIN;
            end
            S_DWR: begin
                cmd.op     = ssk_pkg::OP_DWR;
                state_next = S_DRD;
            end
            S_DFIN: begin
                cmd.op     = ssk_pkg::OP_DFIN;
                state_next = S_DONE;
            end
            S_IFREE: begin
                cmd.op     = ssk_pkg::OP_IFREE;
                state_next = S_CPRD;
            end
            S_CPRD: begin
                cmd.op     = ssk_pkg::OP_CPRD;
                state_next = S_CPWR;
            end
            S_CPWR: begin
                cmd.op     = ssk_pkg::OP_CPWR;
                state_next = stat.copy_last ? S_IQW : S_CPRD;
            end
            S_IQW: begin
                cmd.op     = ssk_pkg::OP_IQW;
                state_next = S_ISRD;
            end
            S_ISRD: begin
                cmd.op     = ssk_pkg::OP_ISRD;
                state_next = stat.sh_more ? S_ISWR : S_IFIN;
            end
            S_ISWR: begin
                cmd.op     = ssk_pkg::OP_ISWR;
                state_next = S_ISRD;
            end
            S_IFIN: begin
                cmd.op     = ssk_pkg::OP_IFIN;
                state_next = S_DONE;
            end
            S_TORD: begin
                cmd.op     = ssk_pkg::OP_TORD;
                state_next = stat.k_more ? S_TQRD : S_DONE;
            end
            S_TQRD: begin
                cmd.op     = ssk_pkg::OP_TQRD;
                state_next = S_TADD;
            end
            S_TADD: begin
                cmd.op     = ssk_pkg::OP_TADD;
                state_next = S_TORD;
            end
            S_DONE: begin
                cmd.op = ssk_pkg::OP_DONE;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ssk_dp.sv =====
// ----------------------------------------------------------------------------
// ssk_dp
// Datapath: key buffers, record stores, sorted order table, search bounds,
// character compare, quantity sum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssk_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ssk_pkg::ssk_cmd_t              cmd,
    output ssk_pkg::ssk_stat_t                  stat,
    input  wire logic                           s_tvalid,
    input  wire logic [ssk_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ssk_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int SLOT_W = ssk_pkg::SLOT_W;
    localparam int CNT_W  = ssk_pkg::CNT_W;
    localparam int POS_W  = ssk_pkg::POS_W;
    localparam int J_W    = ssk_pkg::J_W;
    localparam int TA_W   = ssk_pkg::TA_W;
    localparam int CA_W   = ssk_pkg::CA_W;
    localparam int TLEN_W = ssk_pkg::TLEN_W;
    localparam int CLEN_W = ssk_pkg::CLEN_W;
    localparam int CHAR_W = ssk_pkg::CHAR_W;
    localparam int QTY_W  = ssk_pkg::QTY_W;
    localparam int SUM_W  = ssk_pkg::SUM_W;
    localparam int OPC_W  = ssk_pkg::OPC_W;
    localparam int ST_W   = ssk_pkg::STATUS_W;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // input beat fields
    logic [OPC_W-1:0]  in_opc;
    logic [CHAR_W-1:0] in_tc;
    logic [CHAR_W-1:0] in_cc;
    logic [QTY_W-1:0]  in_qty;
    logic              beat;

    assign in_opc = s_tdata[2:0];
    assign in_tc  = s_tdata[10:3];
    assign in_cc  = s_tdata[18:11];
    assign in_qty = s_tdata[34:19];
    assign beat   = cmd.s_ready && s_tvalid;

    // memories
    logic [SLOT_W-1:0] ord_mem   [ssk_pkg::ENTRIES];
    logic [CHAR_W-1:0] title_mem [ssk_pkg::ENTRIES * ssk_pkg::TITLE_CHARS];
    logic [CHAR_W-1:0] code_mem  [ssk_pkg::ENTRIES * ssk_pkg::CODE_CHARS];
    logic [QTY_W-1:0]  qty_mem   [ssk_pkg::ENTRIES];
    logic [CHAR_W-1:0] tbuf_mem  [ssk_pkg::TITLE_CHARS];
    logic [CHAR_W-1:0] cbuf_mem  [ssk_pkg::CODE_CHARS];

    logic [SLOT_W-1:0] ord_q;
    logic [CHAR_W-1:0] tst_q, cst_q, tb_q, cb_q;
    logic [QTY_W-1:0]  q_q;

    logic              ord_rd_en, ord_wr_en;
    logic [SLOT_W-1:0] ord_rd_addr, ord_wr_addr, ord_wr_data;
    logic              st_rd_en, t_wr_en, c_wr_en;
    logic [TA_W-1:0]   t_rd_addr, t_wr_addr;
    logic [CA_W-1:0]   c_rd_addr, c_wr_addr;
    logic [CHAR_W-1:0] t_wr_data, c_wr_data;
    logic              q_rd_en, q_wr_en;
    logic [SLOT_W-1:0] q_rd_addr, q_wr_addr;
    logic [QTY_W-1:0]  q_wr_data;
    logic              buf_rd_en;

    // registers
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  l_reg, l_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [J_W-1:0]    j_reg, j_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [TLEN_W-1:0] tlen_reg, tlen_next;
    logic [CLEN_W-1:0] clen_reg, clen_next;
    logic [OPC_W-1:0]  opc_reg, opc_next;
    logic [QTY_W-1:0]  qty_reg, qty_next;
    logic [ST_W-1:0]   rst_reg, rst_next;
    logic [QTY_W-1:0]  oldq_reg, oldq_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              tb_ok_reg, tb_ok_next;
    logic              cb_ok_reg, cb_ok_next;
    logic              mv_reg, mv_next;
    logic [ssk_pkg::M_DATA_W-1:0] md_reg, md_next;

    // compare and search
    logic [SLOT_W-1:0] mid;
    logic [CNT_W:0]    mid_sum;
    logic              is_code;
    logic [7:0]        cx, cy;
    logic              j_end;
    logic              out_free;
    logic              srch_more;

    assign is_code   = (opc_reg == ssk_pkg::OPC_FIND_CODE);
    assign mid_sum   = ({1'b0, l_reg} + {1'b0, r_reg} - (CNT_W+1)'(1)) >> 1;
    assign mid       = SLOT_W'(mid_sum);
    assign srch_more = l_reg < r_reg;
    assign out_free  = !mv_reg || m_tready;
    assign cx        = fold(is_code ? cst_q : tst_q);
    assign cy        = is_code ? (cb_ok_reg ? fold(cb_q) : 8'h00)
                               : (tb_ok_reg ? fold(tb_q) : 8'h00);
    assign j_end     = is_code ? (j_reg == J_W'(ssk_pkg::CODE_CHARS - 1))
                               : (j_reg == J_W'(ssk_pkg::TITLE_CHARS - 1));

    always_comb begin
        stat.init_last = (k_reg == CNT_W'(ssk_pkg::ENTRIES - 1));
        stat.beat_last = beat && s_tlast;
        stat.beat_opc  = in_opc;
        stat.opc       = opc_reg;
        stat.full      = (cnt_reg == CNT_W'(ssk_pkg::ENTRIES));
        stat.srch_more = srch_more;
        stat.cmp_done  = (cx != cy) || (cx == 8'h00) || j_end;
        stat.cmp_rel   = (cx < cy) ? ssk_pkg::REL_LT
                       : (cx > cy) ? ssk_pkg::REL_GT : ssk_pkg::REL_EQ;
        stat.k_more    = k_reg < cnt_reg;
        stat.d_more    = (k_reg + CNT_W'(1)) < cnt_reg;
        stat.sh_more   = k_reg > CNT_W'(idx_reg);
        stat.copy_last = (j_reg == J_W'(ssk_pkg::MAX_CHARS - 1));
        stat.out_free  = out_free;
    end

    always_comb begin
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        j_next     = j_reg;
        slot_next  = slot_reg;
        idx_next   = idx_reg;
        tlen_next  = tlen_reg;
        clen_next  = clen_reg;
        opc_next   = opc_reg;
        qty_next   = qty_reg;
        rst_next   = rst_reg;
        oldq_next  = oldq_reg;
        sum_next   = sum_reg;
        tb_ok_next = tb_ok_reg;
        cb_ok_next = cb_ok_reg;
        mv_next    = (mv_reg && m_tready) ? 1'b0 : mv_reg;
        md_next    = md_reg;

        ord_rd_en   = 1'b0;
        ord_rd_addr = mid;
        ord_wr_en   = 1'b0;
        ord_wr_addr = SLOT_W'(k_reg);
        ord_wr_data = ord_q;
        st_rd_en    = 1'b0;
        t_rd_addr   = TA_W'(ord_q) * TA_W'(ssk_pkg::TITLE_CHARS) + TA_W'(j_reg);
        c_rd_addr   = CA_W'(ord_q) * CA_W'(ssk_pkg::CODE_CHARS) + CA_W'(j_reg);
        t_wr_en     = 1'b0;
        c_wr_en     = 1'b0;
        t_wr_addr   = TA_W'(slot_reg) * TA_W'(ssk_pkg::TITLE_CHARS) + TA_W'(j_reg);
        c_wr_addr   = CA_W'(slot_reg) * CA_W'(ssk_pkg::CODE_CHARS) + CA_W'(j_reg);
        t_wr_data   = tb_ok_reg ? tb_q : 8'h00;
        c_wr_data   = cb_ok_reg ? cb_q : 8'h00;
        q_rd_en     = 1'b0;
        q_rd_addr   = slot_reg;
        q_wr_en     = 1'b0;
        q_wr_addr   = slot_reg;
        q_wr_data   = qty_reg;
        buf_rd_en   = 1'b0;

        case (cmd.op)
            ssk_pkg::OP_INIT: begin
                ord_wr_en   = 1'b1;
                ord_wr_data = SLOT_W'(k_reg);
                k_next      = (k_reg == CNT_W'(ssk_pkg::ENTRIES - 1)) ? '0
                                                                     : k_reg + CNT_W'(1);
            end
            ssk_pkg::OP_ACCEPT: begin
                if (beat) begin
                    if (s_tlast) begin
                        pos_next  = '0;
                        tlen_next = (pos_reg < POS_W'(ssk_pkg::TITLE_CHARS))
                                  ? TLEN_W'(pos_reg + POS_W'(1))
                                  : TLEN_W'(ssk_pkg::TITLE_CHARS);
                        clen_next = (pos_reg < POS_W'(ssk_pkg::CODE_CHARS))
                                  ? CLEN_W'(pos_reg + POS_W'(1))
                                  : CLEN_W'(ssk_pkg::CODE_CHARS);
                        opc_next  = in_opc;
                        qty_next  = in_qty;
                        rst_next  = (in_opc == ssk_pkg::OPC_INSERT &&
                                     cnt_reg == CNT_W'(ssk_pkg::ENTRIES))
                                  ? ssk_pkg::ST_FULL : ssk_pkg::ST_DONE;
                        idx_next  = '0;
                        oldq_next = '0;
                        sum_next  = '0;
                        l_next    = '0;
                        r_next    = cnt_reg;
                        k_next    = '0;
                    end else if (pos_reg < POS_W'(ssk_pkg::MAX_CHARS)) begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            ssk_pkg::OP_SRCH: begin
                j_next = '0;
                if (srch_more) begin
                    ord_rd_en   = 1'b1;
                    ord_rd_addr = mid;
                end else if (opc_reg == ssk_pkg::OPC_INSERT) begin
                    ord_rd_en   = 1'b1;
                    ord_rd_addr = SLOT_W'(cnt_reg);
                end else begin
                    rst_next = ssk_pkg::ST_NOT_FOUND;
                end
            end
            ssk_pkg::OP_CISSUE: begin
                st_rd_en   = 1'b1;
                buf_rd_en  = 1'b1;
                slot_next  = ord_q;
                tb_ok_next = TLEN_W'(j_reg) < tlen_reg;
                cb_ok_next = CLEN_W'(j_reg) < clen_reg;
            end
            ssk_pkg::OP_CEVAL: begin
                if (!stat.cmp_done) begin
                    j_next = j_reg + J_W'(1);
                end else if (is_code) begin
                    if (stat.cmp_rel == ssk_pkg::REL_EQ) begin
                        idx_next = SLOT_W'(k_reg);
                    end else begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end else if (opc_reg == ssk_pkg::OPC_INSERT) begin
                    if (stat.cmp_rel == ssk_pkg::REL_GT) begin
                        r_next = CNT_W'(mid);
                    end else begin
                        l_next = CNT_W'(mid) + CNT_W'(1);
                    end
                end else begin
                    case (stat.cmp_rel)
                        ssk_pkg::REL_EQ: idx_next = mid;
                        ssk_pkg::REL_LT: l_next   = CNT_W'(mid) + CNT_W'(1);
                        default:         r_next   = CNT_W'(mid);
                    endcase
                end
            end
            ssk_pkg::OP_CSORD: begin
                j_next = '0;
                if (k_reg < cnt_reg) begin
                    ord_rd_en   = 1'b1;
                    ord_rd_addr = SLOT_W'(k_reg);
                end else begin
                    rst_next = ssk_pkg::ST_NOT_FOUND;
                    idx_next = '0;
                end
            end
            ssk_pkg::OP_QRD: begin
                q_rd_en = 1'b1;
            end
            ssk_pkg::OP_QUSE: begin
                oldq_next = q_q;
                q_wr_en   = (opc_reg == ssk_pkg::OPC_SET_QTY);
                k_next    = CNT_W'(idx_reg);
            end
            ssk_pkg::OP_DRD: begin
                ord_rd_en   = 1'b1;
                ord_rd_addr = SLOT_W'(k_reg + CNT_W'(1));
            end
            ssk_pkg::OP_DWR: begin
                ord_wr_en = 1'b1;
                k_next    = k_reg + CNT_W'(1);
            end
            ssk_pkg::OP_DFIN: begin
                ord_wr_en   = 1'b1;
                ord_wr_addr = SLOT_W'(cnt_reg - CNT_W'(1));
                ord_wr_data = slot_reg;
                cnt_next    = cnt_reg - CNT_W'(1);
            end
            ssk_pkg::OP_IFREE: begin
                slot_next = ord_q;
                idx_next  = SLOT_W'(l_reg);
                j_next    = '0;
            end
            ssk_pkg::OP_CPRD: begin
                buf_rd_en  = 1'b1;
                tb_ok_next = TLEN_W'(j_reg) < tlen_reg;
                cb_ok_next = CLEN_W'(j_reg) < clen_reg;
            end
            ssk_pkg::OP_CPWR: begin
                t_wr_en = {1'b0, j_reg} < (J_W+1)'(ssk_pkg::TITLE_CHARS);
                c_wr_en = {1'b0, j_reg} < (J_W+1)'(ssk_pkg::CODE_CHARS);
                if (!stat.copy_last) begin
                    j_next = j_reg + J_W'(1);
                end
            end
            ssk_pkg::OP_IQW: begin
                q_wr_en = 1'b1;
                k_next  = cnt_reg;
            end
            ssk_pkg::OP_ISRD: begin
                ord_rd_en   = 1'b1;
                ord_rd_addr = SLOT_W'(k_reg - CNT_W'(1));
            end
            ssk_pkg::OP_ISWR: begin
                ord_wr_en = 1'b1;
                k_next    = k_reg - CNT_W'(1);
            end
            ssk_pkg::OP_IFIN: begin
                ord_wr_en   = 1'b1;
                ord_wr_addr = idx_reg;
                ord_wr_data = slot_reg;
                cnt_next    = cnt_reg + CNT_W'(1);
            end
            ssk_pkg::OP_TORD: begin
                ord_rd_en   = 1'b1;
                ord_rd_addr = SLOT_W'(k_reg);
            end
            ssk_pkg::OP_TQRD: begin
                q_rd_en   = 1'b1;
                q_rd_addr = ord_q;
            end
            ssk_pkg::OP_TADD: begin
                sum_next = sum_reg + SUM_W'(q_q);
                k_next   = k_reg + CNT_W'(1);
            end
            ssk_pkg::OP_DONE: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = {sum_reg, oldq_reg, ssk_pkg::INDEX_W'(idx_reg), rst_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            pos_reg <= '0;
            k_reg   <= '0;
            mv_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
            k_reg   <= k_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        l_reg     <= l_next;
        r_reg     <= r_next;
        j_reg     <= j_next;
        slot_reg  <= slot_next;
        idx_reg   <= idx_next;
        tlen_reg  <= tlen_next;
        clen_reg  <= clen_next;
        opc_reg   <= opc_next;
        qty_reg   <= qty_next;
        rst_reg   <= rst_next;
        oldq_reg  <= oldq_next;
        sum_reg   <= sum_next;
        tb_ok_reg <= tb_ok_next;
        cb_ok_reg <= cb_ok_next;
        md_reg    <= md_next;
    end

    always_ff @(posedge aclk) begin
        if (ord_wr_en) begin
            ord_mem[ord_wr_addr] <= ord_wr_data;
        end
        if (ord_rd_en) begin
            ord_q <= ord_mem[ord_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (t_wr_en) begin
            title_mem[t_wr_addr] <= t_wr_data;
        end
        if (st_rd_en) begin
            tst_q <= title_mem[t_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (c_wr_en) begin
            code_mem[c_wr_addr] <= c_wr_data;
        end
        if (st_rd_en) begin
            cst_q <= code_mem[c_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_wr_en) begin
            qty_mem[q_wr_addr] <= q_wr_data;
        end
        if (q_rd_en) begin
            q_q <= qty_mem[q_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (beat && pos_reg < POS_W'(ssk_pkg::TITLE_CHARS)) begin
            tbuf_mem[ssk_pkg::TB_W'(pos_reg)] <= in_tc;
        end
        if (buf_rd_en) begin
            tb_q <= tbuf_mem[ssk_pkg::TB_W'(j_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (beat && pos_reg < POS_W'(ssk_pkg::CODE_CHARS)) begin
            cbuf_mem[ssk_pkg::CB_W'(pos_reg)] <= in_cc;
        end
        if (buf_rd_en) begin
            cb_q <= cbuf_mem[ssk_pkg::CB_W'(j_reg)];
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(ssk_pkg::ENTRIES))
        else $error("record count beyond table size");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ssk_pkg::OP_IFIN) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("insert did not grow the table");

    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ssk_pkg::OP_DFIN) |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("delete did not shrink the table");

    a_title_j: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ssk_pkg::OP_CEVAL && !is_code)
            |-> (j_reg <= J_W'(ssk_pkg::TITLE_CHARS - 1)))
        else $error("title compare ran past key length");

endmodule

`default_nettype wire

// ===== sv/sorted_string_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_string_key_table
// Record table sorted by a case-folded title key, with insert, find, set,
// delete, find-by-code and total operations on streamed key characters.
// ----------------------------------------------------------------------------
// Each beat carries one title and one code character; the beat with tlast
// runs the operation and no beat is taken until its result is loaded.
// Records sit in fixed slots and a sorted order table maps position to slot,
// so insert and delete move order entries rather than whole strings. A key
// compare reads and evaluates one character at a time (up to TITLE_CHARS).
// Find, set and delete: about log2(n+1) compares; delete then shifts the
// later order entries down. Insert: about log2(n+1) compares, a copy of
// max(TITLE_CHARS,CODE_CHARS) characters into the free slot and a shift of
// the later order entries up. Find by code: up to n compares of up to
// CODE_CHARS characters each. Total: reads and sums each record's quantity.
// After reset all ENTRIES (128) order entries are initialized before the
// first beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_string_key_table (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // opcode[2:0], title_char[10:3], code_char[18:11], quantity[34:19], zero pad
    input  wire logic [ssk_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[1:0], entry_index[8:2], old_quantity[24:9], quantity_sum[47:25]
    output logic [ssk_pkg::M_DATA_W-1:0]        m_tdata
);

    ssk_pkg::ssk_cmd_t  cmd;
    ssk_pkg::ssk_stat_t stat;

    assign s_tready = cmd.s_ready;

    ssk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    ssk_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
